// File: hw/rtl/pru_pkg.sv
// shared types, constants and the paeth predictor of the png row unfilter
package pru_pkg;

    // field widths
    localparam int DATA_W = 8;
    localparam int PB_W   = 4;
    localparam int RB_W   = 13;
    localparam int IR_W   = 16;
    localparam int FILT_W = 3;

    // apb register map, 32-bit registers at 4*index
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_BYTES = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_BYTES   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd2;

    // register reset values
    localparam logic [PB_W-1:0] PB_RESET = 4'd4;
    localparam logic [RB_W-1:0] RB_RESET = 13'd4097;
    localparam logic [IR_W-1:0] IR_RESET = 16'd1;

    // filter type codes, unknown types are folded into FILT_BAD
    localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
    localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
    localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
    localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
    localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;
    localparam logic [FILT_W-1:0] FILT_BAD   = 3'd5;

    // raw configuration registers
    typedef struct packed {
        logic [PB_W-1:0] pixel_bytes;
        logic [RB_W-1:0] row_bytes;
        logic [IR_W-1:0] image_rows;
    } t_cfg;

    // one data byte with its row bookkeeping, fixed at input transfer
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [RB_W-1:0]   pos;
        logic [FILT_W-1:0] filter;
        logic              first_row;
        logic              last_row;
        logic              last_img;
    } t_tag;

    // paeth predictor, ties go to left then up
    function automatic logic [DATA_W-1:0] paeth(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b,
                                                input logic [DATA_W-1:0] c);
        logic signed [DATA_W+2:0] p;
        logic signed [DATA_W+2:0] da;
        logic signed [DATA_W+2:0] db;
        logic signed [DATA_W+2:0] dc;
        logic        [DATA_W+2:0] pa;
        logic        [DATA_W+2:0] pb;
        logic        [DATA_W+2:0] pc;
        p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
        da = p - $signed({3'b000, a});
        db = p - $signed({3'b000, b});
        dc = p - $signed({3'b000, c});
        pa = da[DATA_W+2] ? $unsigned(-da) : $unsigned(da);
        pb = db[DATA_W+2] ? $unsigned(-db) : $unsigned(db);
        pc = dc[DATA_W+2] ? $unsigned(-dc) : $unsigned(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/pru_byte_if.sv
// filtered byte stream channel
interface pru_byte_if;
    logic                       valid;
    logic                       ready;
    logic [pru_pkg::DATA_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// File: hw/rtl/pru_pix_if.sv
// reconstructed byte channel with row and image markers
interface pru_pix_if;
    logic                       valid;
    logic                       ready;
    logic [pru_pkg::DATA_W-1:0] pixel_byte;
    logic                       last_in_row;
    logic                       last_in_image;
    logic                       bad_filter;

    modport source (output valid, output pixel_byte, output last_in_row,
                    output last_in_image, output bad_filter, input ready);
    modport sink   (input valid, input pixel_byte, input last_in_row,
                    input last_in_image, input bad_filter, output ready);
endinterface

// File: hw/rtl/pru_apb_regs.sv
// apb configuration registers of the png row unfilter
module pru_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pru_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [pru_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [pru_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output pru_pkg::t_cfg                       o_cfg
);

    pru_pkg::t_cfg                      r_cfg;
    logic                               wr_en;
    logic [pru_pkg::REG_IDX_W-1:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[pru_pkg::REG_IDX_W+1:2];
    assign wr_en   = psel && penable && pwrite;

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_bytes <= pru_pkg::PB_RESET;
            r_cfg.row_bytes   <= pru_pkg::RB_RESET;
            r_cfg.image_rows  <= pru_pkg::IR_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                pru_pkg::REG_PIXEL_BYTES: r_cfg.pixel_bytes <= pwdata[pru_pkg::PB_W-1:0];
                pru_pkg::REG_ROW_BYTES:   r_cfg.row_bytes   <= pwdata[pru_pkg::RB_W-1:0];
                pru_pkg::REG_IMAGE_ROWS:  r_cfg.image_rows  <= pwdata[pru_pkg::IR_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            pru_pkg::REG_PIXEL_BYTES: prdata = pru_pkg::APB_DATA_W'(r_cfg.pixel_bytes);
            pru_pkg::REG_ROW_BYTES:   prdata = pru_pkg::APB_DATA_W'(r_cfg.row_bytes);
            pru_pkg::REG_IMAGE_ROWS:  prdata = pru_pkg::APB_DATA_W'(r_cfg.image_rows);
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/pru_row_ctrl.sv
// row position, row count and filter type tracking at the input side
module pru_row_ctrl #(
    parameter int MAX_LINE = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pru_pkg::t_cfg               i_cfg,
    input  logic                        i_take,
    input  logic [pru_pkg::DATA_W-1:0]  i_data,
    output logic                        o_hdr,
    output pru_pkg::t_tag               o_tag
);

    localparam int RB_W     = pru_pkg::RB_W;
    localparam int IR_W     = pru_pkg::IR_W;
    localparam int RB_LIMIT = (1 << RB_W) - 1;
    localparam int RB_MAX   = (MAX_LINE + 1 > RB_LIMIT) ? RB_LIMIT : MAX_LINE + 1;

    logic [RB_W-1:0]            r_pos;
    logic [IR_W-1:0]            r_row_idx;
    logic [pru_pkg::FILT_W-1:0] r_filter;
    logic                       r_first_row;

    logic [RB_W-1:0]            rb_eff;
    logic [IR_W-1:0]            ir_eff;
    logic [IR_W:0]              row_next;
    logic                       last_row;
    logic                       last_img;

    // clamp row length and row count into their working ranges
    always_comb begin
        if (i_cfg.row_bytes < RB_W'(2)) begin
            rb_eff = RB_W'(2);
        end else if (32'(i_cfg.row_bytes) > RB_MAX) begin
            rb_eff = RB_W'(RB_MAX);
        end else begin
            rb_eff = i_cfg.row_bytes;
        end
        ir_eff = (i_cfg.image_rows == '0) ? IR_W'(1) : i_cfg.image_rows;
    end

    assign o_hdr    = (r_pos == '0);
    assign row_next = {1'b0, r_row_idx} + (IR_W+1)'(1);
    assign last_row = (r_pos >= rb_eff - RB_W'(1));
    assign last_img = last_row && (row_next >= {1'b0, ir_eff});

    assign o_tag.data      = i_data;
    assign o_tag.pos       = r_pos;
    assign o_tag.filter    = r_filter;
    assign o_tag.first_row = r_first_row;
    assign o_tag.last_row  = last_row;
    assign o_tag.last_img  = last_img;

    // advance position and row count on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_row_idx   <= '0;
            r_filter    <= pru_pkg::FILT_NONE;
            r_first_row <= 1'b1;
        end else if (i_take) begin
            if (o_hdr) begin
                r_filter <= (i_data > pru_pkg::DATA_W'(pru_pkg::FILT_PAETH)) ?
                            pru_pkg::FILT_BAD : i_data[pru_pkg::FILT_W-1:0];
                r_pos    <= RB_W'(1);
            end else if (last_row) begin
                r_pos <= '0;
                if (last_img) begin
                    r_row_idx   <= '0;
                    r_first_row <= 1'b1;
                end else begin
                    r_row_idx   <= row_next[IR_W-1:0];
                    r_first_row <= 1'b0;
                end
            end else begin
                r_pos <= r_pos + RB_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/pru_prior_mem.sv
// previous row line buffer, one write and one registered read per cycle
module pru_prior_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [pru_pkg::DATA_W-1:0]  i_wr_data,
    output logic [pru_pkg::DATA_W-1:0]  o_rd_data
);

    logic [pru_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [pru_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read with write-first forwarding for a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/pru_recon.sv
// reconstruction stage: predictor, neighbour histories and result register
module pru_recon #(
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pru_pkg::PB_W-1:0]    i_pixel_bytes,
    input  logic                        i_load,
    input  pru_pkg::t_tag               i_tag,
    input  logic [pru_pkg::DATA_W-1:0]  i_up_raw,
    output logic                        o_ready,
    output logic                        o_wr_en,
    output logic [pru_pkg::RB_W-1:0]    o_wr_pos,
    output logic [pru_pkg::DATA_W-1:0]  o_wr_data,
    pru_pix_if.source                   o_out
);

    localparam int DW = pru_pkg::DATA_W;
    localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic               r_s1_vld;
    pru_pkg::t_tag      r_s1;
    logic [DW-1:0]      r_left [MAX_PIXEL_BYTES];
    logic [DW-1:0]      r_ul   [MAX_PIXEL_BYTES];

    logic               r_out_vld;
    logic [DW-1:0]      r_out_pix;
    logic               r_out_last_row;
    logic               r_out_last_img;
    logic               r_out_bad;

    logic               out_free;
    logic               fire;
    logic [pru_pkg::PB_W-1:0] pb_eff;
    logic [pru_pkg::PB_W-1:0] pb_m1;
    logic [HW-1:0]      hidx;
    logic               have_left;
    logic [DW-1:0]      up;
    logic [DW-1:0]      left;
    logic [DW-1:0]      ul;
    logic [DW:0]        avg_sum;
    logic [DW-1:0]      pred;
    logic [DW-1:0]      val;

    assign out_free = !r_out_vld || o_out.ready;
    assign fire     = r_s1_vld && out_free;
    assign o_ready  = !r_s1_vld || out_free;

    // clamp pixel size and pick the neighbours one pixel back
    always_comb begin
        if (i_pixel_bytes == '0) begin
            pb_eff = pru_pkg::PB_W'(1);
        end else if (32'(i_pixel_bytes) > MAX_PIXEL_BYTES) begin
            pb_eff = pru_pkg::PB_W'(MAX_PIXEL_BYTES);
        end else begin
            pb_eff = i_pixel_bytes;
        end
    end

    assign pb_m1     = pb_eff - pru_pkg::PB_W'(1);
    assign hidx      = pb_m1[HW-1:0];
    assign have_left = (r_s1.pos > pru_pkg::RB_W'(pb_eff));
    assign up        = r_s1.first_row ? '0 : i_up_raw;
    assign left      = have_left ? r_left[hidx] : '0;
    assign ul        = have_left ? r_ul[hidx] : '0;
    assign avg_sum   = {1'b0, left} + {1'b0, up};

    // predictor select
    always_comb begin
        case (r_s1.filter)
            pru_pkg::FILT_SUB:   pred = left;
            pru_pkg::FILT_UP:    pred = up;
            pru_pkg::FILT_AVG:   pred = avg_sum[DW:1];
            pru_pkg::FILT_PAETH: pred = pru_pkg::paeth(left, up, ul);
            default:             pred = '0;
        endcase
    end

    assign val = r_s1.data + pred;

    // stage one holds the tag while the line buffer read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_load || (r_s1_vld && !fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= i_tag;
        end
    end

    // neighbour histories, masked by row position so no clear is needed
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_left[0] <= val;
            r_ul[0]   <= up;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i] <= r_left[i-1];
                r_ul[i]   <= r_ul[i-1];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= fire || (r_out_vld && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_pix      <= val;
            r_out_last_row <= r_s1.last_row;
            r_out_last_img <= r_s1.last_img;
            r_out_bad      <= (r_s1.filter == pru_pkg::FILT_BAD);
        end
    end

    assign o_wr_en   = fire;
    assign o_wr_pos  = r_s1.pos;
    assign o_wr_data = val;

    assign o_out.valid         = r_out_vld;
    assign o_out.pixel_byte    = r_out_pix;
    assign o_out.last_in_row   = r_out_last_row;
    assign o_out.last_in_image = r_out_last_img;
    assign o_out.bad_filter    = r_out_bad;

endmodule

// File: hw/rtl/png_row_unfilter.sv
// Reverses png scanline filtering (None, Sub, Up, Average, Paeth) on a byte
// stream. It takes one byte per cycle, no bubbles, while the output accepts:
// the filter type byte of each row is consumed and gives no output, and every
// other byte waits in stage one for the registered read of the previous-row
// line buffer, then the predictor and modulo-256 add put one reconstructed
// byte in the output register. A result waiting at the output does not block
// the input while the internal stage is free. Unknown filter types pass the
// row through unchanged and set bad_filter on each of its bytes. Configure
// only while idle.
module png_row_unfilter #(
    parameter int MAX_LINE        = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pru_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pru_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pru_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    pru_byte_if.sink                        i_in,
    pru_pix_if.source                       o_out
);

    localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

    pru_pkg::t_cfg                  cfg;
    pru_pkg::t_tag                  tag;
    logic                           hdr;
    logic                           take;
    logic                           data_take;
    logic                           rec_ready;
    logic                           wr_en;
    logic [pru_pkg::RB_W-1:0]       wr_pos;
    logic [pru_pkg::DATA_W-1:0]     wr_data;
    logic [pru_pkg::DATA_W-1:0]     up_raw;
    logic [31:0]                    rd_k;
    logic [31:0]                    wr_k;

    assign i_in.ready = rec_ready;
    assign take       = i_in.valid && rec_ready;
    assign data_take  = take && !hdr;

    // line buffer addresses are the position within the row, less one
    assign rd_k = 32'(tag.pos) - 32'd1;
    assign wr_k = 32'(wr_pos) - 32'd1;

    pru_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pru_row_ctrl #(
        .MAX_LINE (MAX_LINE)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_take  (take),
        .i_data  (i_in.data_byte),
        .o_hdr   (hdr),
        .o_tag   (tag)
    );

    pru_prior_mem #(
        .DEPTH (MAX_LINE),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (data_take),
        .i_rd_addr (rd_k[AW-1:0]),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_k[AW-1:0]),
        .i_wr_data (wr_data),
        .o_rd_data (up_raw)
    );

    pru_recon #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_recon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_bytes (cfg.pixel_bytes),
        .i_load        (data_take),
        .i_tag         (tag),
        .i_up_raw      (up_raw),
        .o_ready       (rec_ready),
        .o_wr_en       (wr_en),
        .o_wr_pos      (wr_pos),
        .o_wr_data     (wr_data),
        .o_out         (o_out)
    );

endmodule

// File: hw/rtl/pru_checker.sv
// port-level checks of the png row unfilter, bound to the top level
module pru_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [pru_pkg::DATA_W-1:0]   i_pixel_byte,
    input logic                         i_last_in_row,
    input logic                         i_last_in_image,
    input logic                         i_bad_filter
);

    logic r_mid_row;
    logic r_prev_bad;
    logic out_xfer;

    assign out_xfer = i_out_valid && i_out_ready;

    // remember whether the next output continues a row, and its flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_row  <= 1'b0;
            r_prev_bad <= 1'b0;
        end else if (out_xfer) begin
            r_mid_row  <= !i_last_in_row;
            r_prev_bad <= i_bad_filter;
        end
    end

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pixel_byte)
            && $stable(i_last_in_row) && $stable(i_last_in_image)
            && $stable(i_bad_filter))
        else $error("stalled result changed");

    // image end only on a row end
    a_img_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_last_in_image || i_last_in_row)
        else $error("last_in_image without last_in_row");

    // bad_filter is the same on every byte of a row
    a_bad_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_mid_row |-> i_bad_filter == r_prev_bad)
        else $error("bad_filter changed within a row");

    // no result right after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // input is taken whenever the output register is empty
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

endmodule

bind png_row_unfilter pru_checker u_pru_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_pixel_byte    (o_out.pixel_byte),
    .i_last_in_row   (o_out.last_in_row),
    .i_last_in_image (o_out.last_in_image),
    .i_bad_filter    (o_out.bad_filter)
);
